/* src/deq_pkg.sv */
// Shared definitions for the double-ended queue: operation and status codes
// and the command and status bundles between the controller and the datapath.
// No dependencies.
package deq_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic capture;
        logic commit;
        logic load_rdata;
    } deq_cmd_t;

    typedef struct packed {
        logic out_free;
        logic read_hit;
    } deq_sts_t;

endpackage

/* src/deq_ram.sv */
// Generic single-port RAM with a registered read for the queue element store.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/deq_ctrl.sv */
// Controller of the double-ended queue: sequences capture, commit and read
// data return for one operation at a time. Depends on deq_pkg.
module deq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  deq_pkg::deq_sts_t sts,
    output deq_pkg::deq_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_RDATA = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        cmd.capture    = (state_reg == ST_IDLE) && s_valid;
        cmd.commit     = (state_reg == ST_EXEC) && sts.out_free;
        cmd.load_rdata = (state_reg == ST_RDATA);
        state_next     = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.out_free) begin
                    state_next = sts.read_hit ? ST_RDATA : ST_IDLE;
                end
            end
            ST_RDATA: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/deq_dpath.sv */
// Datapath of the double-ended queue: operation registers, ring pointers,
// element store and the result register. Depends on deq_pkg and deq_ram.
module deq_dpath #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  deq_pkg::deq_cmd_t            cmd,
    output deq_pkg::deq_sts_t            sts,
    input  logic [deq_pkg::OP_W-1:0]     in_op,
    input  logic [WIDTH-1:0]             in_value,
    input  logic [$clog2(DEPTH)-1:0]     in_pos,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [WIDTH-1:0]             out_value,
    output logic [deq_pkg::STATUS_W-1:0] out_status,
    output logic [$clog2(DEPTH+1)-1:0]   out_occ
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 1;

    logic [deq_pkg::OP_W-1:0]     op_reg;
    logic [WIDTH-1:0]             value_reg;
    logic [ADDR_W-1:0]            pos_reg;
    logic [ADDR_W-1:0]            front_reg;
    logic [ADDR_W-1:0]            front_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [WIDTH-1:0]             out_value_reg;
    logic [deq_pkg::STATUS_W-1:0] out_status_reg;
    logic [deq_pkg::STATUS_W-1:0] status_next;
    logic [CNT_W-1:0]             out_occ_reg;

    logic              full;
    logic              empty;
    logic              in_range;
    logic [SUM_W-1:0]  back_sum;
    logic [SUM_W-1:0]  read_sum;
    logic [SUM_W-1:0]  next_sum;
    logic [ADDR_W-1:0] back_slot;
    logic [ADDR_W-1:0] read_slot;
    logic [ADDR_W-1:0] next_slot;
    logic [ADDR_W-1:0] prev_slot;
    logic              ram_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [WIDTH-1:0]  ram_rdata;

    always_comb begin
        full     = (count_reg == CNT_W'(DEPTH));
        empty    = (count_reg == '0);
        in_range = (CNT_W'(pos_reg) < count_reg);

        back_sum = SUM_W'(front_reg) + SUM_W'(count_reg[ADDR_W-1:0]);
        read_sum = SUM_W'(front_reg) + SUM_W'(pos_reg);
        next_sum = SUM_W'(front_reg) + SUM_W'(1);
        back_slot = (back_sum >= SUM_W'(DEPTH)) ? ADDR_W'(back_sum - SUM_W'(DEPTH))
                                                : ADDR_W'(back_sum);
        read_slot = (read_sum >= SUM_W'(DEPTH)) ? ADDR_W'(read_sum - SUM_W'(DEPTH))
                                                : ADDR_W'(read_sum);
        next_slot = (next_sum >= SUM_W'(DEPTH)) ? ADDR_W'(next_sum - SUM_W'(DEPTH))
                                                : ADDR_W'(next_sum);
        prev_slot = (front_reg == '0) ? ADDR_W'(DEPTH - 1) : front_reg - ADDR_W'(1);

        sts.read_hit = (op_reg == deq_pkg::OP_READ) && in_range;
        sts.out_free = !out_valid_reg || out_ready;

        front_next  = front_reg;
        count_next  = count_reg;
        status_next = deq_pkg::ST_OK;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = read_slot;

        unique case (op_reg)
            deq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    status_next = deq_pkg::ST_FULL;
                end else begin
                    front_next = prev_slot;
                    count_next = count_reg + CNT_W'(1);
                    ram_en     = 1'b1;
                    ram_we     = 1'b1;
                    ram_addr   = prev_slot;
                end
            end
            deq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    status_next = deq_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    ram_en     = 1'b1;
                    ram_we     = 1'b1;
                    ram_addr   = back_slot;
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    status_next = deq_pkg::ST_EMPTY;
                end else begin
                    front_next = next_slot;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    status_next = deq_pkg::ST_EMPTY;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            deq_pkg::OP_READ: begin
                if (in_range) begin
                    ram_en = 1'b1;
                end else begin
                    status_next = deq_pkg::ST_RANGE;
                end
            end
            deq_pkg::OP_CLEAR: begin
                front_next = '0;
                count_next = '0;
            end
            default: begin
            end
        endcase

        if (!cmd.commit) begin
            ram_en = 1'b0;
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.commit && !sts.read_hit) begin
            out_valid_next = 1'b1;
        end
        if (cmd.load_rdata) begin
            out_valid_next = 1'b1;
        end
    end

    deq_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (value_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cmd.commit) begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= in_op;
            value_reg <= in_value;
            pos_reg   <= in_pos;
        end
        if (cmd.commit) begin
            out_value_reg  <= '0;
            out_status_reg <= status_next;
            out_occ_reg    <= count_next;
        end
        if (cmd.load_rdata) begin
            out_value_reg <= ram_rdata;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_occ    = out_occ_reg;

endmodule

/* src/double_ended_queue_top.sv */
// Top level of the double-ended queue: stream ports and field packing.
// Depends on deq_pkg, deq_ctrl and deq_dpath.
//
// Usage: each transfer on the s_axis channel is one operation (push front,
// push back, pop front, pop back, read at a position from the front, clear).
// Every operation returns exactly one result transfer on the m_axis channel
// with the read value, a status code and the element count afterwards.
// Operations are handled one at a time: an operation is taken in the idle
// state and committed in the execute state once the result register is free,
// and no new one is accepted until it is through; a read that hits a stored
// element then also passes the registered read of the element RAM before its
// result is loaded. The result register parts the two
// sides: the next operation is accepted while a result still waits, and the
// commit waits only while that earlier result is not yet taken. When the
// receiver stalls, m_axis_tvalid and m_axis_tdata hold. Reset empties the
// queue and drops any pending result; stored elements are not cleared and
// need no clearing pass.
module double_ended_queue_top #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // op, entry_value, position
    input  logic [((deq_pkg::OP_W + WIDTH + $clog2(DEPTH) + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // read_value, status, occupancy
    output logic [((WIDTH + deq_pkg::STATUS_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
        m_axis_tdata
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OUT_BITS = WIDTH + deq_pkg::STATUS_W + CNT_W;
    localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8;

    deq_pkg::deq_cmd_t            cmd;
    deq_pkg::deq_sts_t            sts;
    logic [WIDTH-1:0]             out_value;
    logic [deq_pkg::STATUS_W-1:0] out_status;
    logic [CNT_W-1:0]             out_occ;

    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    deq_dpath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_axis_tdata[deq_pkg::OP_W-1:0]),
        .in_value   (s_axis_tdata[deq_pkg::OP_W +: WIDTH]),
        .in_pos     (s_axis_tdata[deq_pkg::OP_W + WIDTH +: ADDR_W]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_value  (out_value),
        .out_status (out_status),
        .out_occ    (out_occ)
    );

    assign m_axis_tdata = OUT_W'({out_occ, out_status, out_value});

endmodule

/* dv/double_ended_queue_top_test.sv */
// Self-checking testbench for double_ended_queue_top: random bursts of queue operations
// are checked against an in-bench queue predictor, with back-pressure on the result side.
// Depends on deq_pkg and double_ended_queue_top.
module double_ended_queue_top_test;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int POS_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int IN_W  = ((deq_pkg::OP_W + WIDTH + POS_W + 7) / 8) * 8;
    localparam int OUT_W = ((WIDTH + deq_pkg::STATUS_W + OCC_W + 7) / 8) * 8;
    localparam int RANDOM_OPS = 950;
    localparam int LONG_HOLD  = 80;

    localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0]         position;
        logic [WIDTH-1:0]         entry_value;
        logic [deq_pkg::OP_W-1:0] op;
    } deq_op_t;

    typedef struct packed {
        logic [OCC_W-1:0]             occupancy;
        logic [deq_pkg::STATUS_W-1:0] status;
        logic [WIDTH-1:0]             read_value;
    } deq_result_t;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    deq_op_t     op_queue[$];
    deq_result_t pending_results[$];

    logic [WIDTH-1:0] model_mem[DEPTH];
    logic [POS_W-1:0] model_front = '0;
    logic [OCC_W-1:0] model_count = '0;

    int gen_count    = 0;
    int total_ops    = 0;
    int ops_accepted = 0;
    int results_seen = 0;
    int fail_count   = 0;
    int n_hits       = 0;
    int n_range      = 0;
    int n_full       = 0;
    int n_empty      = 0;

    double_ended_queue_top #(
        .DEPTH(DEPTH),
        .WIDTH(WIDTH)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic deq_result_t apply_deq_op(deq_op_t item);
        deq_result_t res;
        logic [POS_W-1:0] slot;
        res = '0;
        res.status = deq_pkg::ST_OK;
        case (item.op)
            deq_pkg::OP_PUSH_FRONT: begin
                if (model_count == DEPTH) begin
                    res.status = deq_pkg::ST_FULL;
                end else begin
                    model_front = model_front - 1'b1;
                    model_mem[model_front] = item.entry_value;
                    model_count = model_count + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_BACK: begin
                if (model_count == DEPTH) begin
                    res.status = deq_pkg::ST_FULL;
                end else begin
                    slot = model_front + model_count[POS_W-1:0];
                    model_mem[slot] = item.entry_value;
                    model_count = model_count + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (model_count == 0) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else begin
                    model_front = model_front + 1'b1;
                    model_count = model_count - 1'b1;
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (model_count == 0) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else begin
                    model_count = model_count - 1'b1;
                end
            end
            deq_pkg::OP_READ: begin
                if ({1'b0, item.position} >= model_count) begin
                    res.status = deq_pkg::ST_RANGE;
                end else begin
                    slot = model_front + item.position;
                    res.read_value = model_mem[slot];
                end
            end
            deq_pkg::OP_CLEAR: begin
                model_front = '0;
                model_count = '0;
            end
            default: begin
            end
        endcase
        res.occupancy = model_count;
        return res;
    endfunction

    // The generator keeps its own element count so that most reads land inside the queue.
    function automatic void queue_op(logic [deq_pkg::OP_W-1:0] op, logic [WIDTH-1:0] value,
                                     logic [POS_W-1:0] pos);
        deq_op_t item;
        item.op = op;
        item.entry_value = value;
        item.position = pos;
        op_queue.push_back(item);
        total_ops++;
        case (op)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: if (gen_count < DEPTH) gen_count++;
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:   if (gen_count > 0) gen_count--;
            deq_pkg::OP_CLEAR:                             gen_count = 0;
            default: begin
            end
        endcase
    endfunction

    always @(posedge aclk) begin : op_driver
        deq_op_t offered_op;
        deq_result_t predicted;
        int gap_left;
        int burst_left;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left = 0;
            burst_left = $urandom_range(1, 40);
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted = apply_deq_op(offered_op);
                pending_results.push_back(predicted);
                ops_accepted++;
                case (predicted.status)
                    deq_pkg::ST_FULL:  n_full++;
                    deq_pkg::ST_EMPTY: n_empty++;
                    deq_pkg::ST_RANGE: n_range++;
                    default:  if (offered_op.op == deq_pkg::OP_READ) n_hits++;
                endcase
            end
            if (s_axis_tvalid && !s_axis_tready) begin
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (op_queue.size() > 0) begin
                offered_op = op_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(IN_W - $bits(deq_op_t)){1'b0}}, offered_op};
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        deq_result_t got;
        deq_result_t want;
        int rx_cycle;
        int hold_left;
        int next_hold_at;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_cycle = 0;
            hold_left = 0;
            next_hold_at = 150;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(deq_result_t)-1:0];
                results_seen++;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.read_value !== want.read_value) begin
                        fail_count++;
                        $display("%0t: read_value mismatch, expected %h, actual %h",
                                 $time, want.read_value, got.read_value);
                    end
                    if (got.status !== want.status) begin
                        fail_count++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.occupancy !== want.occupancy) begin
                        fail_count++;
                        $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                                 $time, want.occupancy, got.occupancy);
                    end
                end
            end
            rx_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (results_seen >= next_hold_at) begin
                hold_left = LONG_HOLD;
                next_hold_at += 450;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_cycle[7:6])
                    2'd0:    m_axis_tready <= 1'b1;
                    2'd1:    m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2'd2:    m_axis_tready <= (rx_cycle[1:0] == 2'd0);
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int phase;
        int p_push;
        int p_pop;
        int r;
        logic [WIDTH-1:0] value;
        logic [POS_W-1:0] pos;

        queue_op(deq_pkg::OP_POP_FRONT, 32'h1234_5678, '0);
        queue_op(deq_pkg::OP_POP_BACK, 32'hFFFF_FFFF, 4'hF);
        queue_op(deq_pkg::OP_READ, '0, '0);
        queue_op(OP_SPARE_6, 32'hDEAD_BEEF, 4'h5);
        queue_op(OP_SPARE_7, 32'hFFFF_FFFF, 4'hF);
        queue_op(deq_pkg::OP_PUSH_BACK, 32'h0000_0000, '0);
        queue_op(deq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, 4'hF);
        queue_op(deq_pkg::OP_PUSH_FRONT, 32'hA5A5_A5A5, 4'hA);
        queue_op(deq_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A, 4'h5);
        for (int i = 0; i < 4; i++) queue_op(deq_pkg::OP_READ, $urandom, POS_W'(i));
        queue_op(deq_pkg::OP_READ, '0, 4'd4);
        queue_op(deq_pkg::OP_READ, '0, 4'hF);
        queue_op(deq_pkg::OP_POP_FRONT, '0, '0);
        queue_op(deq_pkg::OP_POP_BACK, '0, '0);
        queue_op(deq_pkg::OP_READ, '0, 4'd0);
        queue_op(deq_pkg::OP_READ, '0, 4'd1);
        queue_op(OP_SPARE_6, $urandom, 4'd0);
        queue_op(OP_SPARE_7, $urandom, 4'd1);
        queue_op(deq_pkg::OP_CLEAR, $urandom, 4'd3);
        queue_op(deq_pkg::OP_READ, '0, 4'd0);
        queue_op(deq_pkg::OP_POP_BACK, '0, '0);
        queue_op(deq_pkg::OP_PUSH_FRONT, 32'h0000_0001, '0);

        // Fill, drain and mixed phases drive the queue to full and back to empty repeatedly.
        while (total_ops < RANDOM_OPS + 25) begin
            phase = $urandom_range(0, 2);
            case (phase)
                0:       begin p_push = 70; p_pop = 10; end
                1:       begin p_push = 15; p_pop = 65; end
                default: begin p_push = 38; p_pop = 30; end
            endcase
            repeat ($urandom_range(20, 60)) begin
                r = $urandom_range(0, 99);
                case ($urandom_range(0, 7))
                    0:       value = '0;
                    1:       value = '1;
                    default: value = $urandom;
                endcase
                if (gen_count > 0 && $urandom_range(0, 4) != 0)
                    pos = POS_W'($urandom_range(0, gen_count - 1));
                else
                    pos = POS_W'($urandom_range(0, DEPTH - 1));
                if (r < p_push)
                    queue_op($urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT
                                                  : deq_pkg::OP_PUSH_BACK, value, pos);
                else if (r < p_push + p_pop)
                    queue_op($urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT
                                                  : deq_pkg::OP_POP_BACK, value, pos);
                else if (r < 96)
                    queue_op(deq_pkg::OP_READ, value, pos);
                else if (r < 98)
                    queue_op(deq_pkg::OP_CLEAR, value, pos);
                else
                    queue_op($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, value, pos);
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (ops_accepted < total_ops) @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (pending_results.size() != 0) begin
            fail_count++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end
        $display("Checked %0d operations and %0d results: %0d read hits, %0d reads out of range.",
                 ops_accepted, results_seen, n_hits, n_range);
        $display("Pushes dropped on a full queue: %0d; pops on an empty queue: %0d.",
                 n_full, n_empty);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
